>>> rtl/core/tscd_pkg.sv
// ----------------------------------------------------------------------------
// tscd_pkg: shared types and constants of the tsc current deposit unit
// grid geometry, operation codes, command record and the tsc weight function
// ----------------------------------------------------------------------------
package tscd_pkg;

  localparam int COL_BITS    = 6;
  localparam int ROW_BITS    = 6;
  localparam int GRID_COLS   = 1 << COL_BITS;
  localparam int GRID_ROWS   = 1 << ROW_BITS;
  localparam int CELLS       = GRID_COLS * GRID_ROWS;
  localparam int ADDR_BITS   = COL_BITS + ROW_BITS;
  localparam int ACC_W       = 48;
  localparam int WT_W        = 32;
  localparam int AMP_W       = 48;
  localparam int FRAC_BITS   = 16;
  localparam int UX_W        = FRAC_BITS + COL_BITS;
  localparam int UY_W        = FRAC_BITS + ROW_BITS;
  localparam int INC_W       = 41;
  localparam int QUEUE_DEPTH = 2;

  // operation codes of an input item
  localparam logic [1:0] OP_DEPOSIT    = 2'd0;
  localparam logic [1:0] OP_READ       = 2'd1;
  localparam logic [1:0] OP_READ_CLEAR = 2'd2;
  localparam logic [1:0] OP_IGNORED    = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_INV_WIDTH     = 2'd0;
  localparam logic [1:0] REG_INV_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_CURRENT_SCALE = 2'd2;

  localparam logic [31:0] INV_WIDTH_RESET     = 32'h0001_0000;
  localparam logic [31:0] INV_HEIGHT_RESET    = 32'h0001_0000;
  localparam logic [31:0] CURRENT_SCALE_RESET = 32'h0001_0000;

  localparam logic [WT_W:0]   WT_ONE           = 33'h1_0000_0000;
  localparam logic [WT_W-1:0] WT_THREE_QUARTER = 32'hC000_0000;

  typedef enum logic [1:0] {CMD_DEPOSIT, CMD_READ, CMD_READ_CLEAR} cmd_kind_t;

  typedef logic [2:0][WT_W-1:0] wset_t;

  typedef struct packed {
    wset_t               w;
    logic [COL_BITS-1:0] c;
  } axis_x_t;

  typedef struct packed {
    wset_t               w;
    logic [ROW_BITS-1:0] c;
  } axis_y_t;

  typedef struct packed {
    cmd_kind_t              kind;
    axis_x_t                x1;
    axis_x_t                xh;
    axis_y_t                y1;
    axis_y_t                yh;
    logic [2:0][AMP_W-1:0]  amp;
    logic [2:0]             neg;
    logic [COL_BITS-1:0]    col;
    logic [ROW_BITS-1:0]    row;
  } cmd_t;

  typedef enum logic [3:0] {
    F_IDLE, F_MULT, F_GAMMA, F_SQRT, F_DIV, F_AMP_MUL, F_AMP_SCALE, F_AMP_SUM, F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_CLEAR, B_IDLE, B_DEPOSIT, B_DRAIN, B_READ, B_READ_DATA
  } back_state_t;

  // three quadratic weights from the fraction f of the shifted position
  function automatic wset_t tsc_weights(input logic [FRAC_BITS-1:0] f);
    logic [FRAC_BITS:0]     dm;
    logic [2*FRAC_BITS+1:0] dsq;
    logic [FRAC_BITS-1:0]   xm;
    logic [2*FRAC_BITS-1:0] xsq;
    logic [WT_W:0]          w2;
    wset_t                  w;
    dm   = {1'b1, {FRAC_BITS{1'b0}}} - {1'b0, f};
    dsq  = dm * dm;
    w[0] = dsq[WT_W:1];
    xm   = f[FRAC_BITS-1] ? {1'b0, f[FRAC_BITS-2:0]}
                          : ({1'b1, {(FRAC_BITS-1){1'b0}}} - f);
    xsq  = xm * xm;
    w[1] = WT_THREE_QUARTER - xsq;
    w2   = WT_ONE - {1'b0, w[0]} - {1'b0, w[1]};
    w[2] = w2[WT_W-1:0];
    return w;
  endfunction

endpackage

>>> rtl/core/tscd_if.sv
// ----------------------------------------------------------------------------
// tscd channels: request, response and configuration write
// valid/ready handshakes carrying the item payloads
// ----------------------------------------------------------------------------
interface tscd_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    operation;
  logic signed [31:0]            pos_x;
  logic signed [31:0]            pos_y;
  logic signed [31:0]            mom_x;
  logic signed [31:0]            mom_y;
  logic signed [31:0]            mom_z;
  logic signed [31:0]            charge;
  logic [tscd_pkg::COL_BITS-1:0] cell_col;
  logic [tscd_pkg::ROW_BITS-1:0] cell_row;
  modport source (output valid, operation, pos_x, pos_y, mom_x, mom_y, mom_z, charge,
                  cell_col, cell_row, input ready);
  modport sink (input valid, operation, pos_x, pos_y, mom_x, mom_y, mom_z, charge,
                cell_col, cell_row, output ready);
endinterface

interface tscd_rsp_if;
  logic                                valid;
  logic                                ready;
  logic signed [tscd_pkg::ACC_W-1:0]   sum_jx;
  logic signed [tscd_pkg::ACC_W-1:0]   sum_jy;
  logic signed [tscd_pkg::ACC_W-1:0]   sum_jz;
  modport source (output valid, sum_jx, sum_jy, sum_jz, input ready);
  modport sink (input valid, sum_jx, sum_jy, sum_jz, output ready);
endinterface

interface tscd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [31:0] wdata;
  modport source (output valid, reg_index, wdata, input ready);
  modport sink (input valid, reg_index, wdata, output ready);
endinterface

>>> rtl/core/tsc_current_deposit_2d_unit.sv
// ----------------------------------------------------------------------------
// tsc_current_deposit_2d_unit: quadratic current deposition on three 2d grids
// front prepares particles, a short queue decouples it from the grid engine
// ----------------------------------------------------------------------------
// usage
//   req: one item per handshake; operation deposit, read or read-and-clear
//     (code 3 is dropped). deposits give no result, reads give one on rsp.
//   rsp: sum_jx, sum_jy, sum_jz of the addressed cell, held until taken.
//   cfg: register writes, always ready; write only while the unit is idle.
// flow
//   a deposit passes the front in order: intake, setup, the one-bit-a-step
//   square root of gamma, the three parallel beta dividers, the amplitude
//   multiply, scale and sum steps, and the hand-off to the queue; the front
//   takes no new item until it has handed its command on. the back engine
//   then walks the 9 cells of the stencil, one per cycle on each of the three
//   grid rams, and drains its pipeline. reads go in until the queue fills; the
//   grid engine serves one read at a time, a read waiting while a result is
//   held on rsp. a result comes behind any earlier deposits.
// reset
//   the grids are swept to zero, one cell a cycle, with req.ready
//   low. config registers return to 1.0.
// stall
//   while a result waits on rsp, later deposits still run; a further read
//   holds in the queue and fills it, then req.ready drops.
// ----------------------------------------------------------------------------
module tsc_current_deposit_2d_unit (
  input  logic        clk,
  input  logic        rst,
  tscd_req_if.sink    req,
  tscd_rsp_if.source  rsp,
  tscd_cfg_if.sink    cfg
);

  // front to queue
  logic            push_valid;
  logic            push_ready;
  tscd_pkg::cmd_t  push_cmd;

  // queue to back
  logic            pop_valid;
  logic            pop_ready;
  tscd_pkg::cmd_t  pop_cmd;

  // items are held off until the clearing sweep has finished
  logic            clear_done;

  tscd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .enable     (clear_done),
    .req        (req),
    .cfg        (cfg),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  tscd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  tscd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd),
    .rsp        (rsp),
    .clear_done (clear_done)
  );

endmodule

>>> rtl/core/tscd_ram.sv
// ----------------------------------------------------------------------------
// tscd_ram: generic simple dual-port ram
// one write port, one read port with registered read data (old data on collision)
// ----------------------------------------------------------------------------
module tscd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/tscd_front.sv
// ----------------------------------------------------------------------------
// tscd_front: request intake and particle preparation
// holds the config registers, computes grid position, gamma, beta, amplitudes
// and stencil weights, and hands a command to the queue
// ----------------------------------------------------------------------------
module tscd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            enable,
  tscd_req_if.sink        req,
  tscd_cfg_if.sink        cfg,
  output logic            push_valid,
  input  logic            push_ready,
  output tscd_pkg::cmd_t  push_cmd
);

  localparam logic [tscd_pkg::UX_W-1:0] HALF_X = tscd_pkg::UX_W'(1 << (tscd_pkg::FRAC_BITS-1));
  localparam logic [tscd_pkg::UY_W-1:0] HALF_Y = tscd_pkg::UY_W'(1 << (tscd_pkg::FRAC_BITS-1));

  tscd_pkg::front_state_t state, state_next;

  logic [31:0] inv_w, inv_h, scale;

  logic signed [31:0]          px, py;
  logic [2:0][31:0]            mmag;
  logic [2:0]                  mneg;
  logic [31:0]                 qmag;
  logic                        qneg;
  logic [tscd_pkg::UX_W-1:0]   ux;
  logic [tscd_pkg::UY_W-1:0]   uy;
  logic [2:0][63:0]            sq;
  logic [63:0]                 g_rem, g_root, g_bit;
  logic [2:0][55:0]            div_rem;
  logic [55:0]                 div_dsr;
  logic [2:0][24:0]            beta;
  logic [4:0]                  step;
  logic [2:0][56:0]            xprod;
  logic [2:0][60:0]            ph;
  logic [2:0][59:0]            pl;
  tscd_pkg::cmd_t              cmd;

  logic signed [64:0]          prod_x, prod_y;
  logic [tscd_pkg::UX_W-1:0]   sx1;
  logic [tscd_pkg::UY_W-1:0]   sy1;
  logic [63:0]                 trial, root_next;
  logic                        sq_hit;
  logic [2:0][88:0]            amp_full;
  logic                        accept;

  assign accept = req.valid && req.ready;
  assign cfg.ready = 1'b1;
  assign push_cmd = cmd;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      inv_w <= tscd_pkg::INV_WIDTH_RESET;
      inv_h <= tscd_pkg::INV_HEIGHT_RESET;
      scale <= tscd_pkg::CURRENT_SCALE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        tscd_pkg::REG_INV_WIDTH:     inv_w <= cfg.wdata;
        tscd_pkg::REG_INV_HEIGHT:    inv_h <= cfg.wdata;
        tscd_pkg::REG_CURRENT_SCALE: scale <= cfg.wdata;
        default: ;
      endcase
    end
  end

  assign prod_x = px * $signed({1'b0, inv_w});
  assign prod_y = py * $signed({1'b0, inv_h});
  assign sx1 = ux - HALF_X;
  assign sy1 = uy - HALF_Y;

  assign trial = g_root + g_bit;
  assign sq_hit = g_rem >= trial;
  assign root_next = sq_hit ? ((g_root >> 1) + g_bit) : (g_root >> 1);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      amp_full[i] = {ph[i], 28'd0} + {29'd0, pl[i]};
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tscd_pkg::F_IDLE: begin
        if (accept) begin
          unique case (req.operation)
            tscd_pkg::OP_DEPOSIT:    state_next = tscd_pkg::F_MULT;
            tscd_pkg::OP_READ,
            tscd_pkg::OP_READ_CLEAR: state_next = tscd_pkg::F_PUSH;
            default:                 state_next = tscd_pkg::F_IDLE;
          endcase
        end
      end
      tscd_pkg::F_MULT:      state_next = tscd_pkg::F_GAMMA;
      tscd_pkg::F_GAMMA:     state_next = tscd_pkg::F_SQRT;
      tscd_pkg::F_SQRT:      if (step == 5'd0) state_next = tscd_pkg::F_DIV;
      tscd_pkg::F_DIV:       if (step == 5'd0) state_next = tscd_pkg::F_AMP_MUL;
      tscd_pkg::F_AMP_MUL:   state_next = tscd_pkg::F_AMP_SCALE;
      tscd_pkg::F_AMP_SCALE: state_next = tscd_pkg::F_AMP_SUM;
      tscd_pkg::F_AMP_SUM:   state_next = tscd_pkg::F_PUSH;
      tscd_pkg::F_PUSH:      if (push_ready) state_next = tscd_pkg::F_IDLE;
      default:               state_next = tscd_pkg::F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req.ready  = (state == tscd_pkg::F_IDLE) && enable;
    push_valid = (state == tscd_pkg::F_PUSH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tscd_pkg::F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      tscd_pkg::F_IDLE: begin
        if (accept) begin
          px      <= req.pos_x;
          py      <= req.pos_y;
          mmag[0] <= req.mom_x[31] ? 32'(-req.mom_x) : 32'(req.mom_x);
          mmag[1] <= req.mom_y[31] ? 32'(-req.mom_y) : 32'(req.mom_y);
          mmag[2] <= req.mom_z[31] ? 32'(-req.mom_z) : 32'(req.mom_z);
          mneg    <= {req.mom_z[31], req.mom_y[31], req.mom_x[31]};
          qmag    <= req.charge[31] ? 32'(-req.charge) : 32'(req.charge);
          qneg    <= req.charge[31];
          cmd.col <= req.cell_col;
          cmd.row <= req.cell_row;
          cmd.kind <= (req.operation == tscd_pkg::OP_READ_CLEAR) ? tscd_pkg::CMD_READ_CLEAR :
                      (req.operation == tscd_pkg::OP_READ) ? tscd_pkg::CMD_READ :
                      tscd_pkg::CMD_DEPOSIT;
        end
      end
      tscd_pkg::F_MULT: begin
        ux <= prod_x[tscd_pkg::FRAC_BITS+tscd_pkg::UX_W-1:tscd_pkg::FRAC_BITS];
        uy <= prod_y[tscd_pkg::FRAC_BITS+tscd_pkg::UY_W-1:tscd_pkg::FRAC_BITS];
        for (int i = 0; i < 3; i++) begin
          sq[i] <= mmag[i] * mmag[i];
        end
      end
      tscd_pkg::F_GAMMA: begin
        g_rem  <= 64'h0001_0000_0000_0000 + sq[0] + sq[1] + sq[2];
        g_root <= 64'd0;
        g_bit  <= 64'h4000_0000_0000_0000;
        step   <= 5'd31;
        // offset one cell: shifted position u - 0.5; offset half cell: u
        cmd.x1.w <= tscd_pkg::tsc_weights(sx1[tscd_pkg::FRAC_BITS-1:0]);
        cmd.x1.c <= sx1[tscd_pkg::UX_W-1:tscd_pkg::FRAC_BITS];
        cmd.xh.w <= tscd_pkg::tsc_weights(ux[tscd_pkg::FRAC_BITS-1:0]);
        cmd.xh.c <= ux[tscd_pkg::UX_W-1:tscd_pkg::FRAC_BITS];
        cmd.y1.w <= tscd_pkg::tsc_weights(sy1[tscd_pkg::FRAC_BITS-1:0]);
        cmd.y1.c <= sy1[tscd_pkg::UY_W-1:tscd_pkg::FRAC_BITS];
        cmd.yh.w <= tscd_pkg::tsc_weights(uy[tscd_pkg::FRAC_BITS-1:0]);
        cmd.yh.c <= uy[tscd_pkg::UY_W-1:tscd_pkg::FRAC_BITS];
      end
      tscd_pkg::F_SQRT: begin
        if (sq_hit) begin
          g_rem <= g_rem - trial;
        end
        g_root <= root_next;
        g_bit  <= g_bit >> 2;
        if (step == 5'd0) begin
          for (int i = 0; i < 3; i++) begin
            div_rem[i] <= {mmag[i], 24'd0};
          end
          div_dsr <= {root_next[31:0], 24'd0};
          step    <= 5'd24;
        end else begin
          step <= step - 5'd1;
        end
      end
      tscd_pkg::F_DIV: begin
        for (int i = 0; i < 3; i++) begin
          if (div_rem[i] >= div_dsr) begin
            div_rem[i] <= div_rem[i] - div_dsr;
            beta[i]    <= {beta[i][23:0], 1'b1};
          end else begin
            beta[i]    <= {beta[i][23:0], 1'b0};
          end
        end
        div_dsr <= div_dsr >> 1;
        step    <= step - 5'd1;
      end
      tscd_pkg::F_AMP_MUL: begin
        for (int i = 0; i < 3; i++) begin
          xprod[i] <= qmag * beta[i];
        end
      end
      tscd_pkg::F_AMP_SCALE: begin
        for (int i = 0; i < 3; i++) begin
          ph[i] <= xprod[i][56:28] * scale;
          pl[i] <= xprod[i][27:0] * scale;
        end
      end
      tscd_pkg::F_AMP_SUM: begin
        for (int i = 0; i < 3; i++) begin
          cmd.amp[i] <= amp_full[i][87:40];
          cmd.neg[i] <= qneg ^ mneg[i];
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/tscd_queue.sv
// ----------------------------------------------------------------------------
// tscd_queue: short command queue between front and back
// ----------------------------------------------------------------------------
module tscd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  tscd_pkg::cmd_t  push_cmd,
  output logic            pop_valid,
  input  logic            pop_ready,
  output tscd_pkg::cmd_t  pop_cmd
);

  localparam int PTR_BITS = $clog2(tscd_pkg::QUEUE_DEPTH);

  tscd_pkg::cmd_t        entry [tscd_pkg::QUEUE_DEPTH];
  logic [PTR_BITS-1:0]   wptr, rptr;
  logic [PTR_BITS:0]     count;
  logic                  do_push, do_pop;

  assign push_ready = count != (PTR_BITS+1)'(tscd_pkg::QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_cmd    = entry[rptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      count <= count + (PTR_BITS+1)'(do_push) - (PTR_BITS+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wptr] <= push_cmd;
    end
  end

endmodule

>>> rtl/core/tscd_back.sv
// ----------------------------------------------------------------------------
// tscd_back: grid accumulator engine
// clears the grids after reset, runs 3x3 read-modify-write stencils on the
// three grid memories in parallel, and serves cell reads into the result register
// ----------------------------------------------------------------------------
module tscd_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  tscd_pkg::cmd_t  pop_cmd,
  tscd_rsp_if.source      rsp,
  output logic            clear_done
);

  localparam int EXT_W = tscd_pkg::ACC_W + 1 - tscd_pkg::INC_W;

  tscd_pkg::back_state_t state, state_next;

  tscd_pkg::cmd_t                       cur;
  logic [1:0]                           ia, ib;
  logic [tscd_pkg::ADDR_BITS-1:0]       clr_addr;
  logic                                 s1v, s2v, s3v;
  logic                                 out_valid;
  logic [2:0][tscd_pkg::ACC_W-1:0]      out_sum;
  logic [2:0][tscd_pkg::ACC_W-1:0]      rdata;
  logic [tscd_pkg::ADDR_BITS-1:0]       rd_cell;
  logic                                 do_pop;

  assign do_pop  = pop_valid && pop_ready;
  assign rd_cell = {cur.row, cur.col};

  assign rsp.valid  = out_valid;
  assign rsp.sum_jx = out_sum[0];
  assign rsp.sum_jy = out_sum[1];
  assign rsp.sum_jz = out_sum[2];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      tscd_pkg::B_CLEAR:     if (clr_addr == '1) state_next = tscd_pkg::B_IDLE;
      tscd_pkg::B_IDLE: begin
        if (do_pop) begin
          state_next = (pop_cmd.kind == tscd_pkg::CMD_DEPOSIT) ? tscd_pkg::B_DEPOSIT
                                                               : tscd_pkg::B_READ;
        end
      end
      tscd_pkg::B_DEPOSIT:   if (ia == 2'd2 && ib == 2'd2) state_next = tscd_pkg::B_DRAIN;
      tscd_pkg::B_DRAIN:     if (!(s1v || s2v || s3v)) state_next = tscd_pkg::B_IDLE;
      tscd_pkg::B_READ:      state_next = tscd_pkg::B_READ_DATA;
      tscd_pkg::B_READ_DATA: state_next = tscd_pkg::B_IDLE;
      default:               state_next = tscd_pkg::B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_ready  = (state == tscd_pkg::B_IDLE) &&
                 (pop_cmd.kind == tscd_pkg::CMD_DEPOSIT || !out_valid);
    clear_done = (state != tscd_pkg::B_CLEAR);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tscd_pkg::B_CLEAR;
      clr_addr  <= '0;
      ia        <= 2'd0;
      ib        <= 2'd0;
      s1v       <= 1'b0;
      s2v       <= 1'b0;
      s3v       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      s1v   <= (state == tscd_pkg::B_DEPOSIT);
      s2v   <= s1v;
      s3v   <= s2v;
      if (state == tscd_pkg::B_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == tscd_pkg::B_DEPOSIT) begin
        if (ib == 2'd2) begin
          ib <= 2'd0;
          ia <= ia + 2'd1;
        end else begin
          ib <= ib + 2'd1;
        end
      end else begin
        ia <= 2'd0;
        ib <= 2'd0;
      end
      if (state == tscd_pkg::B_READ_DATA) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_pop) cur <= pop_cmd;
    if (state == tscd_pkg::B_READ_DATA) out_sum <= rdata;
  end

  for (genvar g = 0; g < 3; g++) begin : g_lane
    logic [tscd_pkg::WT_W-1:0]             wx, wy;
    logic [tscd_pkg::COL_BITS-1:0]         cx, col;
    logic [tscd_pkg::ROW_BITS-1:0]         cy, row;
    logic [2*tscd_pkg::WT_W-1:0]           wprod;
    logic [tscd_pkg::WT_W-1:0]             s1_w;
    logic [tscd_pkg::ADDR_BITS-1:0]        s1_addr, s2_addr, s3_addr;
    logic [55:0]                           s2_ph, s2_pl;
    logic [79:0]                           mag_sum;
    logic signed [tscd_pkg::INC_W-1:0]     inc, s3_inc;
    logic signed [tscd_pkg::ACC_W:0]       sum;
    logic [tscd_pkg::ACC_W-1:0]            sat, wdata;
    logic [tscd_pkg::ADDR_BITS-1:0]        waddr, raddr;
    logic                                  we;

    // jx: x offset one cell, y half; jy: x half, y one; jz: both half
    always_comb begin
      if (g == 0) begin
        wx = cur.x1.w[ia];
        cx = cur.x1.c;
      end else begin
        wx = cur.xh.w[ia];
        cx = cur.xh.c;
      end
      if (g == 1) begin
        wy = cur.y1.w[ib];
        cy = cur.y1.c;
      end else begin
        wy = cur.yh.w[ib];
        cy = cur.yh.c;
      end
    end

    // stencil cells wrap around the grid edges
    assign col   = cx + tscd_pkg::COL_BITS'(ia) - tscd_pkg::COL_BITS'(1);
    assign row   = cy + tscd_pkg::ROW_BITS'(ib) - tscd_pkg::ROW_BITS'(1);
    assign wprod = wx * wy;

    assign mag_sum = {s2_ph, 24'd0} + {24'd0, s2_pl};
    assign inc = cur.neg[g] ? -$signed({1'b0, mag_sum[79:40]})
                            : $signed({1'b0, mag_sum[79:40]});

    assign sum = $signed({rdata[g][tscd_pkg::ACC_W-1], rdata[g]}) +
                 $signed({{EXT_W{s3_inc[tscd_pkg::INC_W-1]}}, s3_inc});
    assign sat = (sum[tscd_pkg::ACC_W] == sum[tscd_pkg::ACC_W-1]) ? sum[tscd_pkg::ACC_W-1:0] :
                 {sum[tscd_pkg::ACC_W], {(tscd_pkg::ACC_W-1){~sum[tscd_pkg::ACC_W]}}};

    always_ff @(posedge clk) begin
      s1_w    <= wprod[2*tscd_pkg::WT_W-1:tscd_pkg::WT_W];
      s1_addr <= {row, col};
      s2_ph   <= cur.amp[g][47:24] * s1_w;
      s2_pl   <= cur.amp[g][23:0] * s1_w;
      s2_addr <= s1_addr;
      s3_inc  <= inc;
      s3_addr <= s2_addr;
    end

    always_comb begin
      we    = 1'b0;
      waddr = s3_addr;
      wdata = sat;
      raddr = s2_addr;
      if (state == tscd_pkg::B_CLEAR) begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
      end else if (state == tscd_pkg::B_READ) begin
        raddr = rd_cell;
        we    = (cur.kind == tscd_pkg::CMD_READ_CLEAR);
        waddr = rd_cell;
        wdata = '0;
      end else if (s3v) begin
        we = 1'b1;
      end
    end

    tscd_ram #(
      .WIDTH (tscd_pkg::ACC_W),
      .DEPTH (tscd_pkg::CELLS)
    ) u_grid (
      .clk   (clk),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata[g])
    );
  end

  // no queue traffic while the grids are being cleared
  a_clear_no_pop: assert property (@(posedge clk) disable iff (rst)
    (state == tscd_pkg::B_CLEAR) |-> !pop_ready)
    else $error("command popped during grid clear");

  // the stencil pipeline is empty whenever a new command can start
  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    (state == tscd_pkg::B_IDLE) |-> !(s1v || s2v || s3v))
    else $error("stencil pipeline busy in idle");

  // a result appears only after read data came back
  a_rsp_from_read: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == tscd_pkg::B_READ_DATA))
    else $error("result raised without a read");

  // a read starts only with the result register free
  a_read_free: assert property (@(posedge clk) disable iff (rst)
    (state == tscd_pkg::B_READ) |-> !out_valid)
    else $error("read issued over a pending result");

endmodule

>>> sim/tscd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tscd_checker: grid current predictor and result comparator
// watches the request, response and configuration channels, keeps its own
// three grids and compares each read result with the oldest expected sums
// ----------------------------------------------------------------------------
module tscd_checker (
  input  logic       clk,
  input  logic       rst,
  tscd_req_if        req,
  tscd_rsp_if        rsp,
  tscd_cfg_if        cfg,
  output int         fail_count,
  output int         pending
);
  import tscd_pkg::*;

  localparam longint SUM_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint SUM_MIN = -SUM_MAX - 1;

  typedef struct {
    logic [ACC_W-1:0] jx;
    logic [ACC_W-1:0] jy;
    logic [ACC_W-1:0] jz;
  } cell_sums_t;

  longint     sum_jx_grid [CELLS];
  longint     sum_jy_grid [CELLS];
  longint     sum_jz_grid [CELLS];
  logic [31:0] inv_w, inv_h, scale;
  cell_sums_t expected_sums [$];

  assign pending = expected_sums.size();

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  // centre cell and three q0.32 weights of one axis
  function automatic longint stencil_axis(longint u, longint off,
                                          output logic [63:0] w [3]);
    longint sh, ctr, f, d, x;
    sh  = u - off + 32768;
    ctr = floor_shift(sh, 16);
    f   = sh - ctr * 65536;
    d   = f - 65536;
    x   = f - 32768;
    w[0] = 64'(d * d) >> 1;
    w[1] = (64'd3 << 30) - 64'(x * x);
    w[2] = (64'd1 << 32) - w[0] - w[1];
    return ctr;
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] current_amp(logic [63:0] qmag, longint p,
                                              logic [63:0] gam);
    logic [63:0]  pm, beta;
    logic [127:0] prod;
    pm   = p < 0 ? 64'(-p) : 64'(p);
    beta = (pm << 24) / gam;
    prod = 128'(qmag * beta) * 128'(scale);
    return 64'(prod >> 40);
  endfunction

  function automatic longint sat_sum(longint a, longint d);
    longint v;
    v = a + d;
    if (v > SUM_MAX) v = SUM_MAX;
    if (v < SUM_MIN) v = SUM_MIN;
    return v;
  endfunction

  task automatic spread_current(int comp, longint ux, longint uy, longint offx,
                                longint offy, logic [63:0] amp, bit neg);
    logic [63:0]  wx [3];
    logic [63:0]  wy [3];
    logic [63:0]  w;
    logic [127:0] p;
    longint       cx, cy, inc;
    int           k;
    cx = stencil_axis(ux, offx, wx);
    cy = stencil_axis(uy, offy, wy);
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        k   = ((cy - 1 + b) & (GRID_ROWS - 1)) * GRID_COLS + ((cx - 1 + a) & (GRID_COLS - 1));
        w   = (wx[a] * wy[b]) >> 32;
        p   = 128'(amp) * 128'(w);
        inc = longint'(p >> 40);
        if (neg) inc = -inc;
        case (comp)
          0: sum_jx_grid[k] = sat_sum(sum_jx_grid[k], inc);
          1: sum_jy_grid[k] = sat_sum(sum_jy_grid[k], inc);
          default: sum_jz_grid[k] = sat_sum(sum_jz_grid[k], inc);
        endcase
      end
    end
  endtask

  task automatic deposit_particle();
    longint      px, py, mx, my, mz, q, ux, uy;
    logic [63:0] g2, gam, qm;
    bit          qn;
    px = longint'(req.pos_x);
    py = longint'(req.pos_y);
    mx = longint'(req.mom_x);
    my = longint'(req.mom_y);
    mz = longint'(req.mom_z);
    q  = longint'(req.charge);
    ux = floor_shift(px * longint'({32'd0, inv_w}), 16);
    uy = floor_shift(py * longint'({32'd0, inv_h}), 16);
    g2 = (64'd1 << 48) + 64'(mx * mx) + 64'(my * my) + 64'(mz * mz);
    gam = isqrt(g2);
    qm = q < 0 ? 64'(-q) : 64'(q);
    qn = q < 0;
    spread_current(0, ux, uy, 65536, 32768, current_amp(qm, mx, gam), qn != (mx < 0));
    spread_current(1, ux, uy, 32768, 65536, current_amp(qm, my, gam), qn != (my < 0));
    spread_current(2, ux, uy, 32768, 32768, current_amp(qm, mz, gam), qn != (mz < 0));
  endtask

  always @(posedge clk) begin
    int         k;
    cell_sums_t s, e;
    if (rst) begin
      for (int i = 0; i < CELLS; i++) begin
        sum_jx_grid[i] = 0;
        sum_jy_grid[i] = 0;
        sum_jz_grid[i] = 0;
      end
      inv_w = INV_WIDTH_RESET;
      inv_h = INV_HEIGHT_RESET;
      scale = CURRENT_SCALE_RESET;
      expected_sums.delete();
      fail_count = 0;
    end else begin
      // compare first so an expectation pushed this edge is not consumed early
      if (rsp.valid && rsp.ready) begin
        if (expected_sums.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %h %h %h",
                                         rsp.sum_jx, rsp.sum_jy, rsp.sum_jz);
        end else begin
          e = expected_sums.pop_front();
          if (rsp.sum_jx !== e.jx || rsp.sum_jy !== e.jy || rsp.sum_jz !== e.jz) begin
            fail_count++;
            if (fail_count <= 10)
              $display("sum mismatch: expected %h %h %h got %h %h %h",
                       e.jx, e.jy, e.jz, rsp.sum_jx, rsp.sum_jy, rsp.sum_jz);
          end
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.reg_index)
          REG_INV_WIDTH:     inv_w = cfg.wdata;
          REG_INV_HEIGHT:    inv_h = cfg.wdata;
          REG_CURRENT_SCALE: scale = cfg.wdata;
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        k = int'(req.cell_row) * GRID_COLS + int'(req.cell_col);
        case (req.operation)
          OP_DEPOSIT: deposit_particle();
          OP_READ, OP_READ_CLEAR: begin
            s.jx = sum_jx_grid[k][ACC_W-1:0];
            s.jy = sum_jy_grid[k][ACC_W-1:0];
            s.jz = sum_jz_grid[k][ACC_W-1:0];
            expected_sums.push_back(s);
            if (req.operation == OP_READ_CLEAR) begin
              sum_jx_grid[k] = 0;
              sum_jy_grid[k] = 0;
              sum_jz_grid[k] = 0;
            end
          end
          default: ;
        endcase
      end
    end
  end
endmodule

>>> sim/tb_tsc_current_deposit_2d_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tsc_current_deposit_2d_unit: directed and random deposit and read traffic
// drives particles and cell reads in bursts under response back-pressure,
// walks the scale registers through several settings and takes the verdict
// ----------------------------------------------------------------------------
module tb_tsc_current_deposit_2d_unit;
  import tscd_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   fail_count;
  int   pending;
  int   cycle_count = 0;
  int   gap_left = 0;
  bit   rsp_stall_on = 1'b0;

  tscd_req_if req ();
  tscd_rsp_if rsp ();
  tscd_cfg_if cfg ();

  tsc_current_deposit_2d_unit dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg));

  tscd_checker checker_i (.clk(clk), .rst(rst), .req(req), .rsp(rsp), .cfg(cfg),
                          .fail_count(fail_count), .pending(pending));

  always #10 clk = ~clk;

  // timeout watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL tsc_current_deposit_2d_unit");
      $finish;
    end
  end

  // receiver stall pattern: long free phases, long stall phases and chatter
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b1;
    end else if ($urandom_range(0, 63) == 0) begin
      rsp_stall_on <= ~rsp_stall_on;
    end else if (rsp_stall_on) begin
      rsp.ready <= ($urandom_range(0, 3) == 0);
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  initial begin
    req.valid = 1'b0;
    req.operation = OP_DEPOSIT;
    req.pos_x = '0;
    req.pos_y = '0;
    req.mom_x = '0;
    req.mom_y = '0;
    req.mom_z = '0;
    req.charge = '0;
    req.cell_col = '0;
    req.cell_row = '0;
    cfg.valid = 1'b0;
    cfg.reg_index = REG_INV_WIDTH;
    cfg.wdata = '0;
  end

  // one item; a gap before it when the current burst ends
  task automatic send_item(logic [1:0] op, logic [31:0] px, logic [31:0] py,
                           logic [31:0] mx, logic [31:0] my, logic [31:0] mz,
                           logic [31:0] q, logic [5:0] col, logic [5:0] row);
    if (gap_left == 0 && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 12);
    if (gap_left > 0) begin
      req.valid <= 1'b0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    req.valid     <= 1'b1;
    req.operation <= op;
    req.pos_x     <= px;
    req.pos_y     <= py;
    req.mom_x     <= mx;
    req.mom_y     <= my;
    req.mom_z     <= mz;
    req.charge    <= q;
    req.cell_col  <= col;
    req.cell_row  <= row;
    do @(posedge clk); while (!req.ready);
  endtask

  task automatic idle_req();
    req.valid <= 1'b0;
    @(posedge clk);
  endtask

  // write one register, then drop the write valid
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg.valid     <= 1'b1;
    cfg.reg_index <= idx;
    cfg.wdata     <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_unit();
    idle_req();
    while (pending != 0) @(posedge clk);
    // deposits produce no result and may still be in flight
    repeat (200) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_mom();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
      2: return 32'h8000_0000;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  task automatic random_item(int cells_mask);
    logic [1:0] op;
    int         r;
    r  = $urandom_range(0, 99);
    op = r < 60 ? OP_DEPOSIT : r < 78 ? OP_READ : r < 97 ? OP_READ_CLEAR : OP_IGNORED;
    send_item(op, ($urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h00FF_FFFF)),
              ($urandom_range(0, 1) ? $urandom : $urandom_range(0, 32'h00FF_FFFF)),
              rand_mom(), rand_mom(), rand_mom(),
              ($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0200_0000) - 32'h0100_0000),
              $urandom & cells_mask, $urandom & cells_mask);
  endtask

  initial begin
    int phase;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part: corner fields, wrap at the grid edges, ignored code 3
    send_item(OP_DEPOSIT, 32'h0000_0000, 32'h0000_0000, 32'h0100_0000, 32'h0, 32'h0,
              32'h0100_0000, 0, 0);
    send_item(OP_DEPOSIT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
    send_item(OP_DEPOSIT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 0, 0);
    send_item(OP_DEPOSIT, 32'hFFFF_8000, 32'h003F_8000, 32'hFF00_0000, 32'h0080_0000,
              32'hFFFF_FFFF, 32'hFF00_0000, 0, 0);
    send_item(OP_IGNORED, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, 63, 63);
    send_item(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0);
    send_item(OP_READ, 0, 0, 0, 0, 0, 0, 63, 63);
    send_item(OP_READ_CLEAR, 0, 0, 0, 0, 0, 0, 63, 0);
    send_item(OP_READ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 63);
    send_item(OP_READ, 0, 0, 0, 0, 0, 0, 0, 63);
    // saturation: repeat a huge deposit on one spot
    for (int i = 0; i < 6; i++)
      send_item(OP_DEPOSIT, 32'h0002_0000, 32'h0002_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0);
    send_item(OP_READ, 0, 0, 0, 0, 0, 0, 2, 2);
    send_item(OP_READ_CLEAR, 0, 0, 0, 0, 0, 0, 2, 2);
    drain_unit();

    // phases of register settings, extremes included
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_INV_WIDTH, 32'd0);
          write_reg(REG_INV_HEIGHT, 32'd0);
          write_reg(REG_CURRENT_SCALE, 32'hFFFF_FFFF);
        end
        1: begin
          write_reg(REG_INV_WIDTH, 32'hFFFF_FFFF);
          write_reg(REG_INV_HEIGHT, 32'd1);
          write_reg(REG_CURRENT_SCALE, 32'd0);
        end
        2: begin
          write_reg(REG_INV_WIDTH, 32'd1);
          write_reg(REG_INV_HEIGHT, 32'hFFFF_FFFF);
          write_reg(REG_CURRENT_SCALE, 32'd1);
        end
        default: begin
          write_reg(REG_INV_WIDTH, $urandom_range(1, 32'h0008_0000));
          write_reg(REG_INV_HEIGHT, $urandom_range(1, 32'h0008_0000));
          write_reg(REG_CURRENT_SCALE, $urandom);
        end
      endcase
      // even phases use a small read window to land reads on deposited cells; odd phases read the whole grid
      for (int i = 0; i < 200; i++) random_item(phase[0] ? 63 : 7);
      drain_unit();
    end

    if (fail_count == 0) begin
      $display("PASS tsc_current_deposit_2d_unit");
    end else begin
      $display("FAIL tsc_current_deposit_2d_unit");
    end
    $finish;
  end
endmodule

>>> files.f
rtl/core/tscd_pkg.sv
rtl/core/tscd_if.sv
rtl/core/tscd_ram.sv
rtl/core/tscd_front.sv
rtl/core/tscd_queue.sv
rtl/core/tscd_back.sv
rtl/core/tsc_current_deposit_2d_unit.sv
sim/tscd_checker.sv
sim/tb_tsc_current_deposit_2d_unit.sv
